// File: rtl/dqe_pkg.sv
`timescale 1ns / 1ps

package dqe_pkg;

	localparam int OFF_W = 9;
	localparam int CNT_W = 7;
	localparam int STEP_W = 5;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] NAME_END_CHAR = 8'h00;
	localparam logic [15:0] QDCOUNT_WORD = 16'h0001;
	localparam logic [15:0] CLASS_IN = 16'h0001;
	localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;
	localparam logic [OFF_W-1:0] FIRST_SLOT = 9'd12;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	typedef enum logic [1:0] {
		JOB_WRITE,
		JOB_ERROR,
		JOB_NAME_END
	} job_op_t;

	typedef struct packed {
		job_op_t op;
		logic [OFF_W-1:0] offset;
		logic [7:0] value;
		logic [OFF_W-1:0] pos;
		logic [15:0] query_type;
		logic [15:0] transaction_id;
		logic recursion_desired;
	} job_t;

endpackage

// File: rtl/dqe_in_if.sv
`timescale 1ns / 1ps

interface dqe_in_if;
	logic valid;
	logic ready;
	logic [7:0] name_char;
	logic [15:0] transaction_id;
	logic [15:0] query_type;
	logic recursion_desired;

	modport source(output valid, name_char, transaction_id, query_type, recursion_desired,
		input ready);
	modport sink(input valid, name_char, transaction_id, query_type, recursion_desired,
		output ready);
endinterface

// File: rtl/dqe_out_if.sv
`timescale 1ns / 1ps

interface dqe_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [8:0] byte_offset;
	logic [7:0] byte_value;
	logic [8:0] message_length;
	logic last_of_name;

	modport source(output valid, kind, byte_offset, byte_value, message_length, last_of_name,
		input ready);
	modport sink(input valid, kind, byte_offset, byte_value, message_length, last_of_name,
		output ready);
endinterface

// File: rtl/dns_query_name_encoder.sv
`timescale 1ns / 1ps

// Streams a dotted host name in one character per item and produces addressed byte writes
// that build a DNS query (header at offsets 0-11, question from 12). Ordinary characters and
// dots each give one write; the terminating zero item gives a burst of 18 writes, one per
// cycle from the output stage while ready holds, ending with last_of_name and message_length.
// A four-entry job queue sits between the character front end and the write generator, so
// the front keeps taking characters during a burst until that queue fills. Over-long labels or
// an exhausted name budget give a single error item, and characters are then dropped until
// the zero item, which resets the encoder without output.
module dns_query_name_encoder #(
	parameter int MAX_NAME_BYTES = 255,
	parameter int MAX_LABEL_CHARS = 63
) (
	input logic clk,
	input logic arst_n,
	dqe_in_if.sink name_stream,
	dqe_out_if.source msg_writes
);

	logic push, pop, full, not_empty;
	dqe_pkg::job_t push_job, head;

	dqe_front #(
		.MAX_NAME_BYTES(MAX_NAME_BYTES),
		.MAX_LABEL_CHARS(MAX_LABEL_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.chars(name_stream),
		.full(full),
		.push(push),
		.job(push_job)
	);

	dqe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.head(head)
	);

	dqe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.not_empty(not_empty),
		.head(head),
		.pop(pop),
		.writes(msg_writes)
	);

endmodule

// File: rtl/dqe_front.sv
`timescale 1ns / 1ps

module dqe_front #(
	parameter int MAX_NAME_BYTES = 255,
	parameter int MAX_LABEL_CHARS = 63
) (
	input logic clk,
	input logic arst_n,
	dqe_in_if.sink chars,
	input logic full,
	output logic push,
	output dqe_pkg::job_t job
);

	localparam logic [dqe_pkg::OFF_W-1:0] BUDGET_RESET = dqe_pkg::OFF_W'(MAX_NAME_BYTES - 1);
	localparam logic [dqe_pkg::CNT_W-1:0] LABEL_MAX = dqe_pkg::CNT_W'(MAX_LABEL_CHARS);

	logic [dqe_pkg::OFF_W-1:0] wpos_q, lslot_q, budget_q;
	logic [dqe_pkg::CNT_W-1:0] lcnt_q;
	logic drop_q;
	logic accept, is_end, is_dot, dot_fail, char_fail;

	assign chars.ready = !full;
	assign accept = chars.valid && chars.ready;
	assign is_end = chars.name_char == dqe_pkg::NAME_END_CHAR;
	assign is_dot = chars.name_char == dqe_pkg::DOT_CHAR;
	assign dot_fail = budget_q == '0;
	assign char_fail = (lcnt_q >= LABEL_MAX) || (budget_q <= 9'd1);

	always_comb begin
		job.op = dqe_pkg::JOB_WRITE;
		job.offset = wpos_q;
		job.value = chars.name_char;
		job.pos = wpos_q;
		job.query_type = chars.query_type;
		job.transaction_id = chars.transaction_id;
		job.recursion_desired = chars.recursion_desired;
		push = 1'b0;
		if (accept && !drop_q) begin
			push = 1'b1;
			if (is_end) begin
				job.op = dqe_pkg::JOB_NAME_END;
				job.offset = lslot_q;
				job.value = {1'b0, lcnt_q};
			end else if (is_dot) begin
				job.op = dot_fail ? dqe_pkg::JOB_ERROR : dqe_pkg::JOB_WRITE;
				job.offset = lslot_q;
				job.value = {1'b0, lcnt_q};
			end else if (char_fail) begin
				job.op = dqe_pkg::JOB_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= dqe_pkg::FIRST_SLOT + 9'd1;
			lslot_q <= dqe_pkg::FIRST_SLOT;
			lcnt_q <= '0;
			budget_q <= BUDGET_RESET;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (is_end) begin
				wpos_q <= dqe_pkg::FIRST_SLOT + 9'd1;
				lslot_q <= dqe_pkg::FIRST_SLOT;
				lcnt_q <= '0;
				budget_q <= BUDGET_RESET;
				drop_q <= 1'b0;
			end else if (!drop_q) begin
				if (is_dot) begin
					if (dot_fail) begin
						drop_q <= 1'b1;
					end else begin
						lslot_q <= wpos_q;
						wpos_q <= wpos_q + 9'd1;
						lcnt_q <= '0;
						budget_q <= budget_q - 9'd1;
					end
				end else if (char_fail) begin
					drop_q <= 1'b1;
				end else begin
					wpos_q <= wpos_q + 9'd1;
					lcnt_q <= lcnt_q + 7'd1;
					budget_q <= budget_q - 9'd1;
				end
			end
		end
	end

endmodule

// File: rtl/dqe_queue.sv
`timescale 1ns / 1ps

module dqe_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dqe_pkg::job_t push_job,
	output logic full,
	input logic pop,
	output logic not_empty,
	output dqe_pkg::job_t head
);

	localparam int PTR_W = $clog2(dqe_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(dqe_pkg::QUEUE_DEPTH + 1);

	dqe_pkg::job_t mem_q [dqe_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_W'(dqe_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(dqe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(dqe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into a full job queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from an empty job queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(dqe_pkg::QUEUE_DEPTH)) else $error("job queue count overflow");

endmodule

// File: rtl/dqe_back.sv
`timescale 1ns / 1ps

module dqe_back (
	input logic clk,
	input logic arst_n,
	input logic not_empty,
	input dqe_pkg::job_t head,
	output logic pop,
	dqe_out_if.source writes
);

	logic [dqe_pkg::STEP_W-1:0] step_q;
	logic valid_q, kind_q, last_q;
	logic [dqe_pkg::OFF_W-1:0] off_q, len_q;
	logic [7:0] val_q;
	logic load, job_done;
	logic n_kind, n_last;
	logic [dqe_pkg::OFF_W-1:0] n_off, n_len, body_off, hdr_off;
	logic [7:0] n_val;

	assign load = not_empty && (!valid_q || writes.ready);
	assign job_done = (head.op != dqe_pkg::JOB_NAME_END) || (step_q == dqe_pkg::LAST_STEP);
	assign pop = load && job_done;

	// Body trailer steps count from the terminator slot, header steps from offset 0.
	assign body_off = head.pos + dqe_pkg::OFF_W'(step_q) - 9'd1;
	assign hdr_off = dqe_pkg::OFF_W'(step_q) - 9'd6;

	always_comb begin
		n_kind = dqe_pkg::KIND_WRITE;
		n_last = 1'b0;
		n_len = '0;
		n_off = head.offset;
		n_val = head.value;
		unique case (head.op)
			dqe_pkg::JOB_WRITE: begin
			end
			dqe_pkg::JOB_ERROR: begin
				n_kind = dqe_pkg::KIND_ERROR;
				n_last = 1'b1;
				n_off = '0;
				n_val = '0;
			end
			dqe_pkg::JOB_NAME_END: begin
				if (step_q >= 5'd1 && step_q <= 5'd5) begin
					n_off = body_off;
				end else if (step_q >= 5'd6) begin
					n_off = hdr_off;
				end
				case (step_q)
					5'd0: n_val = head.value;
					5'd2: n_val = head.query_type[15:8];
					5'd3: n_val = head.query_type[7:0];
					5'd4: n_val = dqe_pkg::CLASS_IN[15:8];
					5'd5: n_val = dqe_pkg::CLASS_IN[7:0];
					5'd6: n_val = head.transaction_id[15:8];
					5'd7: n_val = head.transaction_id[7:0];
					5'd8: n_val = {7'd0, head.recursion_desired};
					5'd10: n_val = dqe_pkg::QDCOUNT_WORD[15:8];
					5'd11: n_val = dqe_pkg::QDCOUNT_WORD[7:0];
					default: n_val = '0;
				endcase
				if (step_q == dqe_pkg::LAST_STEP) begin
					n_last = 1'b1;
					n_len = head.pos + 9'd5;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q <= job_done ? '0 : step_q + 5'd1;
			end else if (writes.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= n_kind;
			off_q <= n_off;
			val_q <= n_val;
			len_q <= n_len;
			last_q <= n_last;
		end
	end

	assign writes.valid = valid_q;
	assign writes.kind = kind_q;
	assign writes.byte_offset = off_q;
	assign writes.byte_value = val_q;
	assign writes.message_length = len_q;
	assign writes.last_of_name = last_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= dqe_pkg::LAST_STEP) else $error("burst step out of range");
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && kind_q == dqe_pkg::KIND_ERROR |-> last_q) else $error("error item not last");
	a_len_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> len_q == '0) else $error("length on a non-final item");

endmodule

// File: test/qname_write_checker.sv
`timescale 1ns / 1ps

module qname_write_checker #(
	parameter int MAX_NAME_BYTES = 255,
	parameter int MAX_LABEL_CHARS = 63
) (
	input logic clk,
	input logic arst_n,
	dqe_in_if name_stream,
	dqe_out_if msg_writes,
	output int fail_count,
	output int pending,
	output int writes_checked,
	output int names_encoded,
	output int names_rejected
);

	typedef struct packed {
		logic kind;
		logic [dqe_pkg::OFF_W-1:0] offset;
		logic [7:0] value;
		logic [dqe_pkg::OFF_W-1:0] msg_len;
		logic last;
	} msg_write_t;

	msg_write_t write_queue[$];

	// Shadow of the encoder's name state.
	logic [dqe_pkg::OFF_W-1:0] write_pos;
	logic [dqe_pkg::OFF_W-1:0] len_slot;
	logic [dqe_pkg::CNT_W-1:0] label_len;
	logic [dqe_pkg::OFF_W-1:0] budget;
	logic dropping;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_name();
		write_pos = dqe_pkg::FIRST_SLOT + 9'd1;
		len_slot = dqe_pkg::FIRST_SLOT;
		label_len = '0;
		budget = dqe_pkg::OFF_W'(MAX_NAME_BYTES - 1);
		dropping = 1'b0;
	endtask

	task automatic push_write(input logic [dqe_pkg::OFF_W-1:0] off, input logic [7:0] val,
			input logic [dqe_pkg::OFF_W-1:0] len = '0, input logic last = 1'b0);
		write_queue.push_back('{kind: dqe_pkg::KIND_WRITE, offset: off, value: val,
			msg_len: len, last: last});
	endtask

	task automatic reject_name();
		write_queue.push_back('{kind: dqe_pkg::KIND_ERROR, offset: '0, value: '0, msg_len: '0,
			last: 1'b1});
		dropping = 1'b1;
		names_rejected++;
	endtask

	task automatic encode_item(input logic [7:0] c, input logic [15:0] xid,
			input logic [15:0] qt, input logic rd);
		logic [dqe_pkg::OFF_W-1:0] p;
		if (c == dqe_pkg::NAME_END_CHAR) begin
			if (dropping) begin
				clear_name();
			end else begin
				p = write_pos;
				push_write(len_slot, {1'b0, label_len});
				push_write(p, 8'h00);
				push_write(p + 9'd1, qt[15:8]);
				push_write(p + 9'd2, qt[7:0]);
				push_write(p + 9'd3, dqe_pkg::CLASS_IN[15:8]);
				push_write(p + 9'd4, dqe_pkg::CLASS_IN[7:0]);
				push_write(9'd0, xid[15:8]);
				push_write(9'd1, xid[7:0]);
				push_write(9'd2, {7'd0, rd});
				push_write(9'd3, 8'h00);
				push_write(9'd4, dqe_pkg::QDCOUNT_WORD[15:8]);
				push_write(9'd5, dqe_pkg::QDCOUNT_WORD[7:0]);
				for (int i = 6; i < 11; i++)
					push_write(dqe_pkg::OFF_W'(i), 8'h00);
				push_write(9'd11, 8'h00, p + 9'd5, 1'b1);
				names_encoded++;
				clear_name();
			end
		end else if (!dropping) begin
			if (c == dqe_pkg::DOT_CHAR) begin
				if (budget == '0) begin
					reject_name();
				end else begin
					// Close the label and reserve the next length slot.
					push_write(len_slot, {1'b0, label_len});
					len_slot = write_pos;
					write_pos = write_pos + 9'd1;
					label_len = '0;
					budget = budget - 9'd1;
				end
			end else if (label_len + 1 > MAX_LABEL_CHARS || budget <= 9'd1) begin
				reject_name();
			end else begin
				push_write(write_pos, c);
				write_pos = write_pos + 9'd1;
				label_len = label_len + 7'd1;
				budget = budget - 9'd1;
			end
		end
	endtask

	task automatic compare_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h on write %0d", field, got,
				want, writes_checked));
	endtask

	task automatic check_write();
		msg_write_t want;
		if (write_queue.size() == 0) begin
			report_mismatch($sformatf("unexpected write kind %0b offset %0d value %0h",
				msg_writes.kind, msg_writes.byte_offset, msg_writes.byte_value));
		end else begin
			want = write_queue.pop_front();
			writes_checked++;
			compare_field("kind", 16'(msg_writes.kind), 16'(want.kind));
			compare_field("byte_offset", 16'(msg_writes.byte_offset), 16'(want.offset));
			compare_field("byte_value", 16'(msg_writes.byte_value), 16'(want.value));
			compare_field("message_length", 16'(msg_writes.message_length),
				16'(want.msg_len));
			compare_field("last_of_name", 16'(msg_writes.last_of_name), 16'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_queue.delete();
			clear_name();
			fail_count = 0;
			writes_checked = 0;
			names_encoded = 0;
			names_rejected = 0;
		end else begin
			// An accepted character is predicted before any write of the same edge is checked.
			if (name_stream.valid && name_stream.ready)
				encode_item(name_stream.name_char, name_stream.transaction_id,
					name_stream.query_type, name_stream.recursion_desired);
			if (msg_writes.valid && msg_writes.ready)
				check_write();
		end
		pending = write_queue.size();
	end

endmodule

// File: test/dns_query_name_encoder_test.sv
`timescale 1ns / 1ps

module dns_query_name_encoder_test;

	localparam int NAME_BYTES = 255;
	localparam int LABEL_CHARS = 63;
	localparam int PHASE_ITEMS = 30;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		END_ON_CHAR,
		END_ON_DOT,
		END_CLEAN
	} budget_end_t;

	logic clk;
	logic arst_n;

	int send_idle;
	int recv_idle;
	int items_sent;
	int phase_items;
	int quiet_cycles;

	int fail_count;
	int pending;
	int writes_checked;
	int names_encoded;
	int names_rejected;

	dqe_in_if name_stream();
	dqe_out_if msg_writes();

	dns_query_name_encoder #(
		.MAX_NAME_BYTES(NAME_BYTES),
		.MAX_LABEL_CHARS(LABEL_CHARS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.name_stream(name_stream),
		.msg_writes(msg_writes)
	);

	qname_write_checker #(
		.MAX_NAME_BYTES(NAME_BYTES),
		.MAX_LABEL_CHARS(LABEL_CHARS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.name_stream(name_stream),
		.msg_writes(msg_writes),
		.fail_count(fail_count),
		.pending(pending),
		.writes_checked(writes_checked),
		.names_encoded(names_encoded),
		.names_rejected(names_rejected)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		msg_writes.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((name_stream.valid && name_stream.ready) || (msg_writes.valid && msg_writes.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout after %0d cycles with no item accepted", quiet_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] c, input logic [15:0] xid,
			input logic [15:0] qt, input logic rd);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			name_stream.valid <= 1'b0;
			@(negedge clk);
		end
		name_stream.valid <= 1'b1;
		name_stream.name_char <= c;
		name_stream.transaction_id <= xid;
		name_stream.query_type <= qt;
		name_stream.recursion_desired <= rd;
		@(posedge clk);
		while (!name_stream.ready)
			@(posedge clk);
		items_sent++;
		phase_items++;
	endtask

	// Header fields are randomized on every item; the encoder reads them only on the zero.
	task automatic put_char(input logic [7:0] c);
		send_item(c, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
	endtask

	task automatic end_name();
		send_item(dqe_pkg::NAME_END_CHAR, 16'($urandom), 16'($urandom),
			1'($urandom_range(1)));
	endtask

	function automatic logic [7:0] label_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == dqe_pkg::DOT_CHAR);
		return c;
	endfunction

	task automatic send_label(input int len);
		repeat (len)
			put_char(label_char());
	endtask

	// Runs the name budget down to one byte with random labels, then ends it one of three ways.
	task automatic fill_budget(input budget_end_t how);
		int budget;
		int lab;
		int target;
		budget = NAME_BYTES - 1;
		lab = 0;
		target = $urandom_range(1, LABEL_CHARS);
		while (budget > 1) begin
			if (lab < target) begin
				put_char(label_char());
				lab++;
			end else begin
				put_char(dqe_pkg::DOT_CHAR);
				lab = 0;
				target = $urandom_range(1, LABEL_CHARS);
			end
			budget--;
		end
		case (how)
			END_ON_CHAR: begin
				put_char(label_char());
				repeat ($urandom_range(0, 3))
					put_char(8'($urandom_range(1, 255)));
			end
			END_ON_DOT: begin
				put_char(dqe_pkg::DOT_CHAR);
				put_char(dqe_pkg::DOT_CHAR);
			end
			default: begin
				put_char(dqe_pkg::DOT_CHAR);
			end
		endcase
		end_name();
	endtask

	task automatic send_random_name();
		int pick;
		int labels;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// One character too many in a label, then ignored noise.
			send_label(LABEL_CHARS + 1);
			repeat ($urandom_range(0, 5))
				put_char(8'($urandom_range(1, 255)));
		end else if (pick < 14) begin
			send_label(LABEL_CHARS);
			if ($urandom_range(1)) begin
				put_char(dqe_pkg::DOT_CHAR);
				send_label($urandom_range(1, 8));
			end
		end else if (pick < 20) begin
			repeat ($urandom_range(0, 12))
				put_char(8'($urandom_range(1, 255)));
		end else begin
			labels = $urandom_range(1, 4);
			for (int i = 0; i < labels; i++) begin
				if (i > 0)
					put_char(dqe_pkg::DOT_CHAR);
				send_label(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8));
			end
			if ($urandom_range(7) == 0)
				put_char(dqe_pkg::DOT_CHAR);
		end
		end_name();
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle = 26;
		recv_idle = 63;
		items_sent = 0;
		phase_items = 0;
		quiet_cycles = 0;
		name_stream.valid = 1'b0;
		name_stream.name_char = '0;
		name_stream.transaction_id = '0;
		name_stream.query_type = '0;
		name_stream.recursion_desired = 1'b0;
		msg_writes.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed names: empty name, field extremes, empty labels, trailing dot.
		send_item(dqe_pkg::NAME_END_CHAR, 16'h0000, 16'h0000, 1'b0);
		put_char(8'h01);
		put_char(8'hFF);
		put_char(dqe_pkg::DOT_CHAR);
		put_char(8'h7F);
		send_item(dqe_pkg::NAME_END_CHAR, 16'hFFFF, 16'hFFFF, 1'b1);
		put_char(dqe_pkg::DOT_CHAR);
		put_char(dqe_pkg::DOT_CHAR);
		send_item(dqe_pkg::NAME_END_CHAR, 16'h5A5A, 16'h00FF, 1'b0);
		put_char(8'h80);
		put_char(8'h2D);
		put_char(8'h2F);
		put_char(dqe_pkg::DOT_CHAR);
		send_item(dqe_pkg::NAME_END_CHAR, 16'hA5A5, 16'hFF00, 1'b1);
		put_char(8'h55);
		put_char(8'hAA);
		send_item(dqe_pkg::NAME_END_CHAR, 16'h0001, 16'h001C, 1'b1);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 26 : (ph == 1) ? 63 : 0;
			recv_idle = (ph == 0) ? 63 : (ph == 1) ? 26 : 0;
			// The name budget takes about 255 items to use up, so it is run down only once.
			if (ph == 1)
				fill_budget(END_ON_DOT);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				send_random_name();
		end

		@(negedge clk);
		name_stream.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters over three idle profiles; checked %0d byte writes.",
			items_sent, writes_checked);
		$display("Names encoded: %0d, names rejected: %0d, mismatches: %0d.",
			names_encoded, names_rejected, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
